[design/ostc_pkg.sv]
// Shared types and constants for the order-statistic segment tree core.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package ostc_pkg;

    // Tree geometry.
    localparam int MAX_LEAVES = 64;
    localparam int NODE_DEPTH = 2 * MAX_LEAVES;
    localparam int NODE_W     = $clog2(NODE_DEPTH);
    localparam int LEAF_W     = 6;
    localparam int CFG_W      = 7;
    localparam int DATA_W     = 32;
    // Deepest leaf sits this many levels below the root.
    localparam int LEVELS     = $clog2(MAX_LEAVES);
    localparam int SP_W       = $clog2(LEVELS + 1);

    typedef enum logic [1:0] {
        MODE_BUILD  = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                    mode;
        logic [LEAF_W-1:0]        leaf_index;
        logic signed [DATA_W-1:0] new_value;
        logic signed [DATA_W-1:0] rank_key;
    } in_item_t;

    typedef struct packed {
        logic [LEAF_W-1:0]        found_index;
        logic signed [DATA_W-1:0] root_total;
    } out_item_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_BUILD_STEP,
        CMD_UPD_DESC,
        CMD_UPD_UP,
        CMD_QRY_STEP,
        CMD_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_leaf;
        logic stack_empty;
        logic at_root;
        logic parent_root;
        logic next_leaf;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[design/order_statistic_segment_tree_core.sv]
// Top level of the order-statistic segment tree core: a controller and a datapath.
// Depends on ostc_pkg, ostc_ctrl and ostc_datapath.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_ready    in_data   (in_item_t)
//   out       output     out_valid / out_ready  out_data  (out_item_t)
//   cfg       input      cfg_valid / cfg_ready  cfg_data  (n_used, 7 bits)
//
// One item is worked at a time; the tree walk through the node store (one read and
// one write port) sets the length. A query descends from the root to a leaf, an
// update descends to its leaf and then walks back up to the root, and a build
// visits every tree node. The next item is taken while a finished result
// still waits in the output register; a stalled output holds the core in its final
// state only. Reset clears the node store through per-node valid bits at once, so
// no clearing pass is needed, and sets n_used to 64.
`default_nettype none

module order_statistic_segment_tree_core
    import ostc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller issues one datapath command per cycle; an input transfer is
    // the load command issued from idle.
    ostc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_mode  (in_data.mode),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the tree sums, the walk registers, the leaf-count
    // register and the result register that feeds the output transfer.
    ostc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[design/ostc_ctrl.sv]
// Sequencing state machine for the order-statistic segment tree core.
// Depends on ostc_pkg for the command and status types.
`default_nettype none

module ostc_ctrl
    import ostc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire mode_t      in_mode,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BUILD = 6'b000010,
        S_UDESC = 6'b000100,
        S_UUP   = 6'b001000,
        S_QRY   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = CMD_LOAD;
                    unique case (in_mode)
                        MODE_BUILD:  state_next = S_BUILD;
                        MODE_UPDATE: state_next = S_UDESC;
                        MODE_QUERY:  state_next = S_QRY;
                        MODE_NONE:   state_next = S_DONE;
                    endcase
                end
            end
            S_BUILD:
            begin
                cmd.op = CMD_BUILD_STEP;
                if (status.is_leaf && status.stack_empty)
                begin
                    state_next = S_DONE;
                end
            end
            S_UDESC:
            begin
                cmd.op = CMD_UPD_DESC;
                if (status.is_leaf)
                begin
                    state_next = status.at_root ? S_DONE : S_UUP;
                end
            end
            S_UUP:
            begin
                cmd.op = CMD_UPD_UP;
                if (status.parent_root)
                begin
                    state_next = S_DONE;
                end
            end
            S_QRY:
            begin
                // A one-leaf tree has nothing to descend.
                if (status.is_leaf)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = CMD_QRY_STEP;
                    if (status.next_leaf)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/ostc_datapath.sv]
// Datapath of the order-statistic segment tree core: node store, walk registers,
// build stack, configuration register and result register. Depends on ostc_pkg.
`default_nettype none

module ostc_datapath
    import ostc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire in_item_t          in_data,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output out_item_t              out_data
);

    logic [CFG_W-1:0]         n_used_reg;
    in_item_t                 item_reg;
    logic [LEAF_W-1:0]        l_reg;
    logic [LEAF_W-1:0]        r_reg;
    logic [NODE_W-1:0]        p_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0]        acc_reg;
    logic [SP_W-1:0]          sp_reg;
    logic [LEAF_W-1:0]        stk_l_reg [LEVELS];
    logic [LEAF_W-1:0]        stk_r_reg [LEVELS];
    logic [NODE_W-1:0]        stk_p_reg [LEVELS];

    logic [DATA_W-1:0]        mem [NODE_DEPTH];
    logic [NODE_DEPTH-1:0]    valid_reg;
    logic [DATA_W-1:0]        rd_data_reg;
    logic                     rd_valid_reg;
    logic [DATA_W-1:0]        root_reg;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    logic [CFG_W-1:0]         eff_n;
    logic [CFG_W-1:0]         eff_last;
    logic [LEAF_W-1:0]        mid;
    logic                     is_leaf;
    logic [NODE_W-1:0]        left_p;
    logic [NODE_W-1:0]        p_plus1;
    logic [NODE_W-1:0]        right_p;
    logic [NODE_W-1:0]        parent;
    logic [NODE_W-1:0]        up_sib;
    logic [NODE_W-1:0]        leaf_sib;
    logic [CFG_W-1:0]         span;
    logic signed [DATA_W-1:0] lv;
    logic                     go_left;
    logic [LEAF_W-1:0]        q_l;
    logic [LEAF_W-1:0]        q_r;
    logic [NODE_W-1:0]        q_p;
    logic [NODE_W-1:0]        q_p_plus1;
    logic [DATA_W-1:0]        up_sum;
    logic [SP_W-1:0]          sp_top;
    logic                     wr_en;
    logic [NODE_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [NODE_W-1:0]        rd_addr;

    function automatic logic [NODE_W-1:0] sibling(input logic [NODE_W-1:0] node);
        return node[0] ? node + NODE_W'(1) : node - NODE_W'(1);
    endfunction

    // Leaf count clamped into 1..MAX_LEAVES.
    always_comb
    begin
        priority if (n_used_reg == '0)
        begin
            eff_n = CFG_W'(1);
        end
        else if (n_used_reg > CFG_W'(MAX_LEAVES))
        begin
            eff_n = CFG_W'(MAX_LEAVES);
        end
        else
        begin
            eff_n = n_used_reg;
        end
    end

    assign eff_last  = eff_n - CFG_W'(1);
    assign mid       = l_reg + ((r_reg - l_reg) >> 1);
    assign is_leaf   = (l_reg == r_reg);
    assign left_p    = {p_reg[NODE_W-2:0], 1'b1};
    assign p_plus1   = p_reg + NODE_W'(1);
    assign right_p   = {p_plus1[NODE_W-2:0], 1'b0};
    assign parent    = (p_reg - NODE_W'(1)) >> 1;
    assign up_sib    = sibling(parent);
    assign leaf_sib  = sibling(p_reg);
    assign span      = {1'b0, r_reg} - {1'b0, l_reg} + CFG_W'(1);
    assign sp_top    = sp_reg - SP_W'(1);

    // Unwritten nodes read as zero.
    assign lv        = rd_valid_reg ? rd_data_reg : '0;
    assign go_left   = (lv >= key_reg);
    assign up_sum    = acc_reg + lv;
    assign q_l       = go_left ? l_reg : mid + LEAF_W'(1);
    assign q_r       = go_left ? mid : r_reg;
    assign q_p       = go_left ? left_p : right_p;
    assign q_p_plus1 = q_p;

    assign status.is_leaf     = is_leaf;
    assign status.stack_empty = (sp_reg == '0);
    assign status.at_root     = (p_reg == '0);
    assign status.parent_root = (parent == '0);
    assign status.next_leaf   = (q_l == q_r);
    assign status.out_free    = !out_valid_reg || out_ready;

    // Node store port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = p_reg;
        wr_data = acc_reg;
        rd_addr = left_p;
        unique case (cmd.op)
            CMD_LOAD:
            begin
                rd_addr = NODE_W'(1);
            end
            CMD_BUILD_STEP:
            begin
                wr_en   = 1'b1;
                wr_data = DATA_W'(span);
            end
            CMD_UPD_DESC:
            begin
                wr_en   = is_leaf;
                rd_addr = leaf_sib;
            end
            CMD_UPD_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = parent;
                wr_data = up_sum;
                rd_addr = up_sib;
            end
            CMD_QRY_STEP:
            begin
                rd_addr = {q_p_plus1[NODE_W-2:0], 1'b1};
            end
            CMD_NONE, CMD_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            root_reg     <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en && (wr_addr == '0))
            begin
                root_reg <= wr_data;
            end
        end
    end

    // Configuration register; the user must write it only while the core is idle; the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_used_reg <= CFG_W'(MAX_LEAVES);
        end
        else if (cfg_valid)
        begin
            n_used_reg <= cfg_data;
        end
    end

    // Walk control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            if (cmd.op == CMD_LOAD)
            begin
                sp_reg <= '0;
            end
            else if (cmd.op == CMD_BUILD_STEP)
            begin
                if (!is_leaf)
                begin
                    sp_reg <= sp_reg + SP_W'(1);
                end
                else if (sp_reg != '0)
                begin
                    sp_reg <= sp_top;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            CMD_LOAD:
            begin
                item_reg <= in_data;
                l_reg    <= '0;
                r_reg    <= eff_last[LEAF_W-1:0];
                p_reg    <= '0;
                key_reg  <= in_data.rank_key;
                acc_reg  <= in_data.new_value;
            end
            CMD_BUILD_STEP:
            begin
                if (!is_leaf)
                begin
                    stk_l_reg[sp_reg] <= mid + LEAF_W'(1);
                    stk_r_reg[sp_reg] <= r_reg;
                    stk_p_reg[sp_reg] <= right_p;
                    r_reg             <= mid;
                    p_reg             <= left_p;
                end
                else if (sp_reg != '0)
                begin
                    l_reg <= stk_l_reg[sp_top];
                    r_reg <= stk_r_reg[sp_top];
                    p_reg <= stk_p_reg[sp_top];
                end
            end
            CMD_UPD_DESC:
            begin
                if (!is_leaf)
                begin
                    if (item_reg.leaf_index <= mid)
                    begin
                        r_reg <= mid;
                        p_reg <= left_p;
                    end
                    else
                    begin
                        l_reg <= mid + LEAF_W'(1);
                        p_reg <= right_p;
                    end
                end
            end
            CMD_UPD_UP:
            begin
                acc_reg <= up_sum;
                p_reg   <= parent;
            end
            CMD_QRY_STEP:
            begin
                l_reg   <= q_l;
                r_reg   <= q_r;
                p_reg   <= q_p;
                key_reg <= go_left ? key_reg : key_reg - lv;
            end
            CMD_NONE, CMD_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == CMD_FINISH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_FINISH)
        begin
            out_data_reg.found_index <= (item_reg.mode == MODE_QUERY) ? l_reg : '0;
            out_data_reg.root_total  <= root_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
